// ===== rtl/igsdp_pkg.sv =====
// ----------------------------------------------------------------------------
// igsdp_pkg
// Shared widths and control types of the int8 group-scaled dot product.
// ----------------------------------------------------------------------------
package igsdp_pkg;

   localparam int LANE_BITS         = 8;
   localparam int MAX_LANES         = 8;
   localparam int PACKED_W          = LANE_BITS * MAX_LANES;
   localparam int PROD_W            = 2 * LANE_BITS;
   localparam int SCALE_W           = 32;
   localparam int ROW_W             = 64;
   localparam int ROW_FRACTION_BITS = 24;

   // flags that travel with a beat or a closed group down the pipe
   typedef struct packed {
      logic valid;
      logic close;
      logic last;
   } beat_ctl_type;

endpackage

// ===== rtl/igsdp_req_if.sv =====
// ----------------------------------------------------------------------------
// igsdp_req_if
// Beat channel: packed weights, activations, group scale and row end mark.
// ----------------------------------------------------------------------------
interface igsdp_req_if;
   logic                              valid;
   logic                              ready;
   logic [igsdp_pkg::PACKED_W-1:0]    weight_lanes;
   logic [igsdp_pkg::PACKED_W-1:0]    activation_lanes;
   logic [igsdp_pkg::SCALE_W-1:0]     group_scale;
   logic                              row_end;

   modport source (
      output valid, weight_lanes, activation_lanes, group_scale, row_end,
      input  ready
   );
   modport sink (
      input  valid, weight_lanes, activation_lanes, group_scale, row_end,
      output ready
   );
endinterface

// ===== rtl/igsdp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// igsdp_rsp_if
// Result channel: saturated row sum and sticky overflow flag.
// ----------------------------------------------------------------------------
interface igsdp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [igsdp_pkg::ROW_W-1:0]   row_sum;
   logic                                 overflow;

   modport source (
      output valid, row_sum, overflow,
      input  ready
   );
   modport sink (
      input  valid, row_sum, overflow,
      output ready
   );
endinterface

// ===== rtl/int8_group_scaled_dot_product.sv =====
// ----------------------------------------------------------------------------
// int8_group_scaled_dot_product
// Int8 group-quantised dot product of one matrix row, scaled per group and
// summed into a saturating 64-bit row accumulator with 24 fraction bits.
// ----------------------------------------------------------------------------
//  channel  | dir | carries                                          | transfer
//  req_ch   | in  | weight_lanes, activation_lanes, group_scale,     | valid & ready
//           |     | row_end                                          |
//  rsp_ch   | out | row_sum, overflow                                | valid & ready
//
//  One beat is taken per cycle. A row's result passes the lane register,
//  which loads on the transfer of its row_end beat, then the merge, multiply
//  and align registers, and the row add into the output register. Reset is
//  synchronous and clears the pipe's control flags, the group and row state.
//  While a result waits in the output register and the sink is not ready,
//  the whole pipe holds and req_ch.ready is low.
// ----------------------------------------------------------------------------
module int8_group_scaled_dot_product #(
   parameter int GROUP_ELEMENTS      = 64,
   parameter int LANES               = 8,
   parameter int SCALE_FRACTION_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   igsdp_req_if.sink     req_ch,
   igsdp_rsp_if.source   rsp_ch
);

   // beats per group, and the width of the exact group sum: each product is
   // at most 2^14 in magnitude, so a full group needs clog2(count)+14+2 bits
   localparam int BEATS   = GROUP_ELEMENTS / LANES;
   localparam int BCW     = (BEATS > 1) ? $clog2(BEATS) : 1;
   localparam int GROUP_W = $clog2(BEATS * LANES * (1 << 14)) + 2;
   localparam int ROW_W   = igsdp_pkg::ROW_W;

   localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
   localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

   // one enable for the whole pipe: it moves when the output register is
   // free or being emptied this cycle
   logic                                      adv;
   logic                                      accept;
   logic                                      close;
   logic [BCW-1:0]                            beat_cnt_ff;
   logic [BCW-1:0]                            beat_cnt_in;
   igsdp_pkg::beat_ctl_type                   beat_ctl;

   igsdp_pkg::beat_ctl_type                   lane_ctl;
   logic [LANES-1:0][igsdp_pkg::PROD_W-1:0]   lane_prod;
   logic [igsdp_pkg::SCALE_W-1:0]             lane_scale;

   igsdp_pkg::beat_ctl_type                   grp_ctl;
   logic signed [GROUP_W-1:0]                 grp_sum;
   logic [igsdp_pkg::SCALE_W-1:0]             grp_scale;

   igsdp_pkg::beat_ctl_type                   term_ctl;
   logic signed [ROW_W-1:0]                   term;
   logic                                      term_sat;

   logic signed [ROW_W-1:0]                   row_acc_ff;
   logic signed [ROW_W-1:0]                   row_acc_in;
   logic                                      sticky_ff;
   logic                                      sticky_in;
   logic signed [ROW_W:0]                     row_wide;
   logic signed [ROW_W-1:0]                   row_next;
   logic                                      sticky_next;
   logic                                      row_fire;

   logic                                      rsp_valid_ff;
   logic                                      rsp_valid_in;
   logic signed [ROW_W-1:0]                   rsp_sum_ff;
   logic                                      rsp_ovf_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign accept       = req_ch.valid && adv;

   // group boundary: count beats, close on a full group or at row end
   assign close = req_ch.row_end || (beat_cnt_ff == BCW'(BEATS - 1));

   always_comb begin
      beat_cnt_in = beat_cnt_ff;
      if (accept) begin
         beat_cnt_in = close ? '0 : beat_cnt_ff + 1'b1;
      end
      beat_ctl.valid = accept;
      beat_ctl.close = close;
      beat_ctl.last  = req_ch.row_end;
   end

   igsdp_lanes #(
      .LANES (LANES)
   ) u_lanes (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .ctl_in           (beat_ctl),
      .weight_lanes     (req_ch.weight_lanes),
      .activation_lanes (req_ch.activation_lanes),
      .scale_in         (req_ch.group_scale),
      .ctl_out          (lane_ctl),
      .prod_out         (lane_prod),
      .scale_out        (lane_scale)
   );

   igsdp_merge #(
      .LANES   (LANES),
      .GROUP_W (GROUP_W)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl_in    (lane_ctl),
      .prod_in   (lane_prod),
      .scale_in  (lane_scale),
      .ctl_out   (grp_ctl),
      .gsum_out  (grp_sum),
      .scale_out (grp_scale)
   );

   igsdp_scale #(
      .GROUP_W             (GROUP_W),
      .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (grp_ctl),
      .gsum_in  (grp_sum),
      .scale_in (grp_scale),
      .ctl_out  (term_ctl),
      .term_out (term),
      .sat_out  (term_sat)
   );

   // row add: one guard bit shows signed overflow, then clamp
   always_comb begin
      row_wide    = {term[ROW_W-1], term} + {row_acc_ff[ROW_W-1], row_acc_ff};
      row_next    = row_wide[ROW_W-1:0];
      sticky_next = sticky_ff | term_sat;
      if (row_wide[ROW_W] != row_wide[ROW_W-1]) begin
         row_next    = row_wide[ROW_W] ? ROW_MIN : ROW_MAX;
         sticky_next = 1'b1;
      end

      row_fire   = adv && term_ctl.valid && term_ctl.last;
      row_acc_in = row_acc_ff;
      sticky_in  = sticky_ff;
      if (adv && term_ctl.valid) begin
         row_acc_in = term_ctl.last ? '0 : row_next;
         sticky_in  = term_ctl.last ? 1'b0 : sticky_next;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (row_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_cnt_ff  <= '0;
         row_acc_ff   <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_cnt_ff  <= beat_cnt_in;
         row_acc_ff   <= row_acc_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (row_fire) begin
         rsp_sum_ff <= row_next;
         rsp_ovf_ff <= sticky_next;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.row_sum  = rsp_sum_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

   // beat counter never reaches a full group
   a_beat_cnt_range : assert property (@(posedge clock) disable iff (reset)
      beat_cnt_ff <= BCW'(BEATS - 1))
      else $error("beat counter past group length");

   // emitting a row leaves a clean row accumulator behind
   a_row_clears : assert property (@(posedge clock) disable iff (reset)
      row_fire |=> (row_acc_ff == '0) && !sticky_ff)
      else $error("row state not cleared after row end");

   // no beat is counted while the pipe is held
   a_hold_no_count : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(beat_cnt_ff))
      else $error("beat counted while pipe held");

   // a held result is not overwritten by a new row
   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_sum_ff) && rsp_valid_ff)
      else $error("pending result overwritten");

endmodule

// ===== rtl/igsdp_lanes.sv =====
// ----------------------------------------------------------------------------
// igsdp_lanes
// One 8x8 signed multiplier per lane; products registered.
// ----------------------------------------------------------------------------
module igsdp_lanes #(
   parameter int LANES = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  igsdp_pkg::beat_ctl_type                      ctl_in,
   input  logic [igsdp_pkg::PACKED_W-1:0]               weight_lanes,
   input  logic [igsdp_pkg::PACKED_W-1:0]               activation_lanes,
   input  logic [igsdp_pkg::SCALE_W-1:0]                scale_in,
   output igsdp_pkg::beat_ctl_type                      ctl_out,
   output logic [LANES-1:0][igsdp_pkg::PROD_W-1:0]      prod_out,
   output logic [igsdp_pkg::SCALE_W-1:0]                scale_out
);

   igsdp_pkg::beat_ctl_type                       ctl_ff;
   logic [LANES-1:0][igsdp_pkg::PROD_W-1:0]       prod_ff;
   logic [LANES-1:0][igsdp_pkg::PROD_W-1:0]       prod_in;
   logic [igsdp_pkg::SCALE_W-1:0]                 scale_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [igsdp_pkg::LANE_BITS-1:0] w_byte;
      logic signed [igsdp_pkg::LANE_BITS-1:0] a_byte;
      logic signed [igsdp_pkg::PROD_W-1:0]    product;

      assign w_byte     = weight_lanes[igsdp_pkg::LANE_BITS*l +: igsdp_pkg::LANE_BITS];
      assign a_byte     = activation_lanes[igsdp_pkg::LANE_BITS*l +: igsdp_pkg::LANE_BITS];
      assign product    = w_byte * a_byte;
      assign prod_in[l] = product;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         scale_ff <= scale_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign prod_out  = prod_ff;
   assign scale_out = scale_ff;

endmodule

// ===== rtl/igsdp_merge.sv =====
// ----------------------------------------------------------------------------
// igsdp_merge
// Adds the lane products into the group sum; hands on the sum at group close.
// ----------------------------------------------------------------------------
module igsdp_merge #(
   parameter int LANES   = 8,
   parameter int GROUP_W = 22
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  igsdp_pkg::beat_ctl_type                      ctl_in,
   input  logic [LANES-1:0][igsdp_pkg::PROD_W-1:0]      prod_in,
   input  logic [igsdp_pkg::SCALE_W-1:0]                scale_in,
   output igsdp_pkg::beat_ctl_type                      ctl_out,
   output logic signed [GROUP_W-1:0]                    gsum_out,
   output logic [igsdp_pkg::SCALE_W-1:0]                scale_out
);

   logic signed [GROUP_W-1:0]      gacc_ff;
   logic signed [GROUP_W-1:0]      gacc_in;
   logic signed [GROUP_W-1:0]      beat_sum;
   logic signed [GROUP_W-1:0]      gsum_ff;
   logic [igsdp_pkg::SCALE_W-1:0]  scale_ff;
   igsdp_pkg::beat_ctl_type        ctl_ff;
   igsdp_pkg::beat_ctl_type        ctl_in_next;

   always_comb begin
      beat_sum = gacc_ff;
      for (int l = 0; l < LANES; l++) begin
         beat_sum = beat_sum + GROUP_W'($signed(prod_in[l]));
      end
      gacc_in = gacc_ff;
      if (ctl_in.valid) begin
         gacc_in = ctl_in.close ? '0 : beat_sum;
      end
      ctl_in_next.valid = ctl_in.valid & ctl_in.close;
      ctl_in_next.close = ctl_in.close;
      ctl_in_next.last  = ctl_in.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gacc_ff <= '0;
         ctl_ff  <= '0;
      end else if (adv) begin
         gacc_ff <= gacc_in;
         ctl_ff  <= ctl_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gsum_ff  <= beat_sum;
         scale_ff <= scale_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign gsum_out  = gsum_ff;
   assign scale_out = scale_ff;

endmodule

// ===== rtl/igsdp_scale.sv =====
// ----------------------------------------------------------------------------
// igsdp_scale
// Group sum times scale, then alignment to the row's fraction bits.
// ----------------------------------------------------------------------------
module igsdp_scale #(
   parameter int GROUP_W             = 22,
   parameter int SCALE_FRACTION_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  igsdp_pkg::beat_ctl_type              ctl_in,
   input  logic signed [GROUP_W-1:0]            gsum_in,
   input  logic [igsdp_pkg::SCALE_W-1:0]        scale_in,
   output igsdp_pkg::beat_ctl_type              ctl_out,
   output logic signed [igsdp_pkg::ROW_W-1:0]   term_out,
   output logic                                 sat_out
);

   localparam int SHIFT = SCALE_FRACTION_BITS - igsdp_pkg::ROW_FRACTION_BITS;
   localparam int RSH   = (SHIFT > 0) ? SHIFT : 0;
   localparam int LSH   = (SHIFT < 0) ? -SHIFT : 0;
   localparam int PW    = GROUP_W + igsdp_pkg::SCALE_W + 1;
   // wide enough for the shifted product and for the 64-bit limits plus sign
   localparam int AW_P  = PW + LSH + 1;
   localparam int AW    = (AW_P > igsdp_pkg::ROW_W + 1) ? AW_P : igsdp_pkg::ROW_W + 1;

   localparam logic signed [AW-1:0] HALF   = AW'((64'd1 << RSH) >> 1);
   localparam logic signed [AW-1:0] SAT_HI =
      {{(AW - igsdp_pkg::ROW_W + 1){1'b0}}, {(igsdp_pkg::ROW_W - 1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

   logic signed [PW-1:0]                 gsum_ext;
   logic signed [PW-1:0]                 scale_ext;
   logic signed [PW-1:0]                 prod_in;
   logic signed [PW-1:0]                 prod_ff;
   igsdp_pkg::beat_ctl_type              mul_ctl_ff;
   logic signed [AW-1:0]                 rounded;
   logic signed [AW-1:0]                 shifted;
   logic signed [igsdp_pkg::ROW_W-1:0]   term_in;
   logic                                 sat_in;
   logic signed [igsdp_pkg::ROW_W-1:0]   term_ff;
   logic                                 sat_ff;
   igsdp_pkg::beat_ctl_type              aln_ctl_ff;

   assign gsum_ext  = PW'(gsum_in);
   assign scale_ext = {{(PW - igsdp_pkg::SCALE_W){1'b0}}, scale_in};
   assign prod_in   = gsum_ext * scale_ext;

   // round to nearest, ties up, when the scale carries extra fraction bits;
   // shift left with saturation when it carries fewer
   always_comb begin
      rounded = (AW'(prod_ff) + HALF) >>> RSH;
      shifted = rounded <<< LSH;
      sat_in  = 1'b0;
      if (shifted > SAT_HI) begin
         term_in = SAT_HI[igsdp_pkg::ROW_W-1:0];
         sat_in  = 1'b1;
      end else if (shifted < SAT_LO) begin
         term_in = SAT_LO[igsdp_pkg::ROW_W-1:0];
         sat_in  = 1'b1;
      end else begin
         term_in = shifted[igsdp_pkg::ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         aln_ctl_ff <= '0;
      end else if (adv) begin
         mul_ctl_ff <= ctl_in;
         aln_ctl_ff <= mul_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         term_ff <= term_in;
         sat_ff  <= sat_in;
      end
   end

   assign ctl_out  = aln_ctl_ff;
   assign term_out = term_ff;
   assign sat_out  = sat_ff;

endmodule

// ===== tb/int8_group_scaled_dot_product_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_group_scaled_dot_product_test
// Drives rows of int8 weight/activation beats into the group-scaled dot
// product, predicts each row sum and overflow flag in a local model and checks
// every result transfer against the oldest pending row, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module int8_group_scaled_dot_product_test;

   // block configuration, passed to the DUT so both sides agree
   localparam int GROUP_ELEMENTS      = 64;
   localparam int LANES               = 8;
   localparam int SCALE_FRACTION_BITS = 24;

   localparam int BEATS_PER_GROUP = GROUP_ELEMENTS / LANES;
   localparam int SCALE_SHIFT     = SCALE_FRACTION_BITS - igsdp_pkg::ROW_FRACTION_BITS;

   localparam int RANDOM_BEATS = 1030;
   localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
   localparam int DRAIN_CYCLES = 12;    // pipe is five deep, plus margin

   localparam logic [igsdp_pkg::SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;  // 1.0 in Q8.24
   localparam logic [igsdp_pkg::SCALE_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;
   localparam longint ROW_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ROW_MIN = 64'sh8000_0000_0000_0000;

   typedef struct {
      logic signed [igsdp_pkg::ROW_W-1:0] row_sum;
      logic                               overflow;
   } row_result_type;

   logic clock;
   logic reset;

   igsdp_req_if req();
   igsdp_rsp_if rsp();

   int8_group_scaled_dot_product #(
      .GROUP_ELEMENTS      (GROUP_ELEMENTS),
      .LANES               (LANES),
      .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req.sink),
      .rsp_ch (rsp.source)
   );

   // ------------------------------------------------------------------------
   // Row model state: mirrors the block's group and row accumulators
   // ------------------------------------------------------------------------
   int             beats_in_group;
   longint         group_acc;
   longint         row_acc;
   bit             row_saturated;
   row_result_type pending_rows[$];

   int error_count;
   int quiet_cycles;
   bit tx_full_rate;   // sender never idles while set
   bit rx_full_rate;   // receiver never stalls while set

   // Folds one accepted beat into the model; on row_end the finished row is
   // queued as the next expected result.
   function automatic void fold_beat(input logic [igsdp_pkg::PACKED_W-1:0] weights,
                                     input logic [igsdp_pkg::PACKED_W-1:0] acts,
                                     input logic [igsdp_pkg::SCALE_W-1:0] scale,
                                     input logic last);
      longint prod;
      longint term;
      longint half;
      longint lim;
      int     sh;
      row_result_type row;
      for (int i = 0; i < LANES; i++)
         group_acc += longint'($signed(weights[8*i +: 8])) *
                      longint'($signed(acts[8*i +: 8]));
      beats_in_group++;
      // group closes on its last beat, or early when the row ends
      if (beats_in_group >= BEATS_PER_GROUP || last) begin
         prod = group_acc * longint'({32'b0, scale});
         term = prod;
         sh   = SCALE_SHIFT;
         if (sh > 0) begin
            // round to nearest, ties towards plus infinity
            half = 64'sd1 <<< (sh - 1);
            term = (prod + half) >>> sh;
         end else if (sh < 0) begin
            lim = ROW_MAX >>> (-sh);
            if (prod > lim) begin
               term = ROW_MAX;
               row_saturated = 1'b1;
            end else if (prod < -lim - 1) begin
               term = ROW_MIN;
               row_saturated = 1'b1;
            end else begin
               term = prod <<< (-sh);
            end
         end
         // saturating add into the row
         if (term > 0 && row_acc > ROW_MAX - term) begin
            row_acc = ROW_MAX;
            row_saturated = 1'b1;
         end else if (term < 0 && row_acc < ROW_MIN - term) begin
            row_acc = ROW_MIN;
            row_saturated = 1'b1;
         end else begin
            row_acc += term;
         end
         group_acc      = 0;
         beats_in_group = 0;
      end
      if (last) begin
         row.row_sum  = row_acc;
         row.overflow = row_saturated;
         pending_rows.push_back(row);
         row_acc        = 0;
         row_saturated  = 1'b0;
         group_acc      = 0;
         beats_in_group = 0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Sender: one beat per call, random idle gap first. Entered and left on a
   // rising edge; valid stays high straight into the next call when there is
   // no gap, so it never gets two assignments in one step.
   // ------------------------------------------------------------------------
   function automatic int sender_gap();
      int r;
      if (tx_full_rate)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_beat(input logic [igsdp_pkg::PACKED_W-1:0] weights,
                            input logic [igsdp_pkg::PACKED_W-1:0] acts,
                            input logic [igsdp_pkg::SCALE_W-1:0] scale,
                            input logic last);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid            <= 1'b1;
      req.weight_lanes     <= weights;
      req.activation_lanes <= acts;
      req.group_scale      <= scale;
      req.row_end          <= last;
      // ready is settled by the falling edge; the transfer is the next rise
      forever begin
         @(negedge clock);
         if (req.ready)
            break;
      end
      @(posedge clock);
      fold_beat(weights, acts, scale, last);
   endtask

   // drop valid, then pause on rising edges until no row is outstanding
   task automatic wait_rows_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_rows.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: ready driven at the rising edge, mostly high, short and long
   // stalls mixed in.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      int r;
      stall_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_full_rate) begin
            rsp.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp.ready <= 1'b1;
            end else begin
               rsp.ready <= 1'b0;
               stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result check: valid and ready are stable at the falling edge, and the
   // transfer completes at the following rise.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : check_rows
      row_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rows.size() == 0) begin
            report_mismatch("unexpected row", rsp.row_sum, 64'b0);
         end else begin
            want = pending_rows.pop_front();
            if (rsp.row_sum !== want.row_sum)
               report_mismatch("row_sum", rsp.row_sum, want.row_sum);
            if (rsp.overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp.overflow), 64'(want.overflow));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: counts cycles with no transfer on either channel
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // one full group at lane extremes, closed by a row_end beat at max scale
   task automatic test_lane_extremes();
      tx_full_rate = 1'b0;
      rx_full_rate = 1'b0;
      send_beat({8{8'h80}}, {8{8'h80}}, $urandom, 1'b0);
      send_beat({8{8'h7F}}, {8{8'h80}}, $urandom, 1'b0);
      send_beat({8{8'h7F}}, {8{8'h7F}}, $urandom, 1'b0);
      send_beat({8{8'h80}}, {8{8'h7F}}, $urandom, 1'b0);
      send_beat(64'h0,      {8{8'hFF}}, $urandom, 1'b0);
      send_beat({8{8'hFF}}, {8{8'hFF}}, $urandom, 1'b0);
      send_beat(64'h807F_01FF_0080_7F01, 64'h7F80_FF01_8000_817F, $urandom, 1'b0);
      send_beat({8{8'h80}}, {8{8'h80}}, SCALE_MAX, 1'b1);
   endtask

   // rows ending mid-group: a one-beat row, and a full group plus two beats
   task automatic test_partial_groups();
      send_beat({8{8'h80}}, {8{8'h81}}, SCALE_ONE, 1'b1);
      for (int i = 0; i < BEATS_PER_GROUP; i++)
         send_beat({$urandom, $urandom}, {$urandom, $urandom},
                   (i == BEATS_PER_GROUP - 1) ? SCALE_MAX : $urandom, 1'b0);
      send_beat({8{8'h7F}}, {8{8'h80}}, $urandom, 1'b0);
      send_beat({8{8'h80}}, {8{8'h80}}, SCALE_ONE, 1'b1);
   endtask

   // zero, largest and smallest non-zero scale on single-beat rows
   task automatic test_scale_extremes();
      tx_full_rate = 1'b1;
      rx_full_rate = 1'b1;
      send_beat({8{8'h80}}, {8{8'h80}}, 32'h0, 1'b1);
      send_beat({8{8'h80}}, {8{8'h7F}}, SCALE_MAX, 1'b1);
      send_beat({8{8'h7F}}, {8{8'h7F}}, 32'h1, 1'b1);
   endtask

   // sender holds off until every row has come back, then resumes
   task automatic test_drain_pause();
      tx_full_rate = 1'b0;
      rx_full_rate = 1'b0;
      send_beat({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b0);
      send_beat({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b1);
      wait_rows_drained();
   endtask

   function automatic logic [igsdp_pkg::PACKED_W-1:0] random_lanes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return {$urandom, $urandom};
      if (r < 92)
         return {8{$urandom_range(0, 1) ? 8'h80 : 8'h7F}};
      return '0;
   endfunction

   function automatic logic [igsdp_pkg::SCALE_W-1:0] random_scale();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom;
      if (r < 85)
         return $urandom_range(0, 32'h0200_0000);
      if (r < 93)
         return SCALE_MAX;
      return '0;
   endfunction

   // random rows, mostly whole groups, the rest from one beat up to three groups long
   task automatic test_random_rows();
      int sent;
      int row_len;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 11) == 0) begin
            tx_full_rate = ($urandom_range(0, 2) == 0);
            rx_full_rate = ($urandom_range(0, 2) == 0);
         end
         if ($urandom_range(0, 24) == 0)
            wait_rows_drained();
         if ($urandom_range(0, 99) < 65)
            row_len = BEATS_PER_GROUP * $urandom_range(1, 3);
         else
            row_len = $urandom_range(1, 3 * BEATS_PER_GROUP);
         for (int i = 0; i < row_len; i++)
            send_beat(random_lanes(), random_lanes(), random_scale(), i == row_len - 1);
         sent += row_len;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      beats_in_group = 0;
      group_acc      = 0;
      row_acc        = 0;
      row_saturated  = 1'b0;
      error_count    = 0;
      quiet_cycles   = 0;
      tx_full_rate   = 1'b0;
      rx_full_rate   = 1'b0;

      reset                <= 1'b1;
      req.valid            <= 1'b0;
      req.weight_lanes     <= '0;
      req.activation_lanes <= '0;
      req.group_scale      <= '0;
      req.row_end          <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_lane_extremes();
      test_partial_groups();
      test_scale_extremes();
      test_drain_pause();
      test_random_rows();

      rx_full_rate = 1'b0;
      wait_rows_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/igsdp_pkg.sv
rtl/igsdp_req_if.sv
rtl/igsdp_rsp_if.sv
rtl/igsdp_lanes.sv
rtl/igsdp_merge.sv
rtl/igsdp_scale.sv
rtl/int8_group_scaled_dot_product.sv
tb/int8_group_scaled_dot_product_test.sv
